// ===== design/sorted_unique_key_table_top_defines.svh =====
// Assertion macros for the checker file of the sorted key table.
`ifndef SORTED_UNIQUE_KEY_TABLE_TOP_DEFINES_SVH
`define SORTED_UNIQUE_KEY_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SUK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SUK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/suk_pkg.sv =====
package suk_pkg;

  // Table geometry.
  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // Request type codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // One request beat.
  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] key_x;
    logic signed [DATA_W-1:0] value_y;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic       ok;
    logic [5:0] entry_count;
  } rsp_t;

  // One stored table entry.
  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } entry_t;

  // Memory port controls from the sequencer.
  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } ram_req_t;

endpackage

// ===== design/suk_ram.sv =====
module suk_ram (
  input  logic              clk_i,
  input  suk_pkg::ram_req_t ram_req_i,
  output suk_pkg::entry_t   rdata_o
);

  suk_pkg::entry_t mem_q [suk_pkg::CAPACITY];
  suk_pkg::entry_t rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (ram_req_i.we) begin
      mem_q[ram_req_i.waddr] <= ram_req_i.wdata;
    end
    if (ram_req_i.re) begin
      rdata_q <= mem_q[ram_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/suk_ctrl.sv =====
module suk_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  suk_pkg::req_t     req_i,
  output logic              busy_o,
  output logic              rsp_valid_o,
  output suk_pkg::rsp_t     rsp_o,
  output suk_pkg::ram_req_t ram_req_o,
  input  suk_pkg::entry_t   rdata_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                         state_q, state_d;
  logic [suk_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [suk_pkg::CNT_W-1:0]    ridx_q, ridx_d;
  logic                         dvld_q, dvld_d;
  logic [suk_pkg::IDX_W-1:0]    didx_q, didx_d;
  logic                         found_q, found_d;
  suk_pkg::entry_t              carry_q, carry_d;
  suk_pkg::req_t                req_q, req_d;
  logic                         rsp_vld_q, rsp_vld_d;
  suk_pkg::rsp_t                rsp_q, rsp_d;
  suk_pkg::entry_t              new_ent;

  assign new_ent.key   = req_q.key_x;
  assign new_ent.value = req_q.value_y;

  // Sequencer: reads entries upward one per cycle and, in the cycle after
  // each read, writes the shifted entries. The write always targets an entry
  // other than the one being read, so no forwarding is needed.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ridx_d    = ridx_q;
    dvld_d    = 1'b0;
    didx_d    = didx_q;
    found_d   = found_q;
    carry_d   = carry_q;
    req_d     = req_q;
    rsp_vld_d = 1'b0;
    rsp_d     = rsp_q;
    ram_req_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          ridx_d  = '0;
          found_d = 1'b0;
          // A full table refuses any insert without scanning.
          if (req_i.req_type == suk_pkg::REQ_INSERT &&
              cnt_q == suk_pkg::CNT_W'(suk_pkg::CAPACITY)) begin
            rsp_vld_d         = 1'b1;
            rsp_d.ok          = 1'b0;
            rsp_d.entry_count = 6'(cnt_q);
          end else begin
            state_d = ST_RUN;
          end
        end
      end

      ST_RUN: begin
        // Issue the next read while entries remain.
        if (ridx_q < cnt_q) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = ridx_q[suk_pkg::IDX_W-1:0];
          ridx_d          = ridx_q + 1'b1;
          dvld_d          = 1'b1;
          didx_d          = ridx_q[suk_pkg::IDX_W-1:0];
        end

        if (dvld_q) begin
          if (req_q.req_type == suk_pkg::REQ_INSERT) begin
            if (found_q) begin
              // Ripple the displaced entry one place up.
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = didx_q;
              ram_req_o.wdata = carry_q;
              carry_d         = rdata_i;
            end else if (rdata_i.key == req_q.key_x) begin
              // Duplicate key: stop with nothing changed.
              dvld_d            = 1'b0;
              state_d           = ST_IDLE;
              rsp_vld_d         = 1'b1;
              rsp_d.ok          = 1'b0;
              rsp_d.entry_count = 6'(cnt_q);
            end else if (rdata_i.key > req_q.key_x) begin
              // Ordered position found: place the new entry here.
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = didx_q;
              ram_req_o.wdata = new_ent;
              carry_d         = rdata_i;
              found_d         = 1'b1;
            end
          end else begin
            if (found_q) begin
              // Close the gap left by the deleted entry.
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = didx_q - 1'b1;
              ram_req_o.wdata = rdata_i;
            end else if (rdata_i.key == req_q.key_x) begin
              found_d = 1'b1;
            end
          end
        end else if (ridx_q >= cnt_q) begin
          // Scan finished: the closing write of an insert and the result beat.
          state_d   = ST_IDLE;
          rsp_vld_d = 1'b1;
          if (req_q.req_type == suk_pkg::REQ_INSERT) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = cnt_q[suk_pkg::IDX_W-1:0];
            ram_req_o.wdata = found_q ? carry_q : new_ent;
            cnt_d           = cnt_q + 1'b1;
            rsp_d.ok        = 1'b1;
          end else if (found_q) begin
            cnt_d    = cnt_q - 1'b1;
            rsp_d.ok = 1'b1;
          end else begin
            rsp_d.ok = 1'b0;
          end
          rsp_d.entry_count = 6'(cnt_d);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      dvld_q    <= 1'b0;
      rsp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      ridx_q    <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      dvld_q    <= dvld_d;
      rsp_vld_q <= rsp_vld_d;
      found_q   <= found_d;
      ridx_q    <= ridx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    didx_q  <= didx_d;
    carry_q <= carry_d;
    req_q   <= req_d;
    rsp_q   <= rsp_d;
  end

  assign busy_o      = (state_q == ST_RUN);
  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== design/sorted_unique_key_table_top.sv =====
// Channel   Handshake            Payload
// request   start & !busy        req_i  (req_type, key_x, value_y)
// result    rsp_valid_o strobe   rsp_o  (ok, entry_count)
//
// After a request is accepted, busy stays high while the sequencer reads the
// entry memory, one entry per cycle, takes the registered read data and ends
// the scan, an insert with a closing write. The result strobe comes in the
// next cycle. An insert into a full table never raises busy and strobes in
// the cycle after acceptance. A duplicate insert stops at the match.
// Reset empties the table at once; no clearing pass is run.
// The result is shown for one cycle and cannot be held off; a new request
// may be accepted in the cycle the previous result is shown.
module sorted_unique_key_table_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  suk_pkg::req_t req_i,
  output logic          busy,
  output logic          rsp_valid_o,
  output suk_pkg::rsp_t rsp_o
);

  suk_pkg::ram_req_t ram_req;
  suk_pkg::entry_t   rdata;

  // Entry memory holding key and value side by side.
  suk_ram u_ram (
    .clk_i     (clk_i),
    .ram_req_i (ram_req),
    .rdata_o   (rdata)
  );

  // Scan and shift sequencer.
  suk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i),
    .busy_o      (busy),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .ram_req_o   (ram_req),
    .rdata_i     (rdata)
  );

endmodule

// ===== design/suk_checker.sv =====
`include "sorted_unique_key_table_top_defines.svh"

module suk_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input suk_pkg::req_t req_i,
  input logic          busy,
  input logic          rsp_valid_o,
  input suk_pkg::rsp_t rsp_o
);

  logic [5:0] last_cnt_q;
  logic       last_type_q;
  logic       accept;

  assign accept = start && !busy;

  // Track the count of the last result and the type of the pending request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cnt_q  <= '0;
      last_type_q <= suk_pkg::REQ_INSERT;
    end else begin
      if (rsp_valid_o) begin
        last_cnt_q <= rsp_o.entry_count;
      end
      if (accept) begin
        last_type_q <= req_i.req_type;
      end
    end
  end

  `SUK_ASSERT_NXT(a_accept_progress, clk_i, rst_ni, accept, busy || rsp_valid_o, "accepted beat neither busy nor answered")
  `SUK_ASSERT_NOW(a_busy_end_answers, clk_i, rst_ni, $fell(busy), rsp_valid_o, "busy dropped without a result beat")
  `SUK_ASSERT_NOW(a_fail_keeps_count, clk_i, rst_ni, rsp_valid_o && !rsp_o.ok, rsp_o.entry_count == last_cnt_q, "failed request changed the count")
  `SUK_ASSERT_NOW(a_insert_grows, clk_i, rst_ni, rsp_valid_o && rsp_o.ok && last_type_q == suk_pkg::REQ_INSERT, rsp_o.entry_count == last_cnt_q + 6'd1, "insert did not grow the count by one")

endmodule

bind sorted_unique_key_table_top suk_checker u_suk_checker (.*);
